// ===== rtl/xdc_pkg.sv =====
// Shared types and constants of the cross-correlation direction compare block.
// Used by the top level; no dependencies of its own.
package xdc_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int EPS_W    = 40;
   localparam int PEAK_W   = 41;
   localparam int DIFF_W   = PEAK_W + 1;
   localparam int REQ_W    = 2 * SAMPLE_W;
   localparam int RSP_W    = 88;

   // Register reset value (0.1 in Q12.28) and peak saturation bound (2^39)
   localparam logic [EPS_W-1:0] EPS_RESET  = 40'd26843546;
   localparam longint           PEAK_LIMIT = 64'sd549755813888;

   // Direction codes
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_BOTH  = 2'd2;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_LOAD   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_CLAMP  = 6'b001000,
      ST_DIFF   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // Tag that travels with each product term down the MAC pipeline
   typedef struct packed {
      logic valid;   // term present
      logic first;   // first term of a lag
      logic lastk;   // final term of a lag
      logic lag0;    // term belongs to lag zero
   } tag_type;

endpackage

// ===== rtl/xdc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module xdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr0,
   output logic [WIDTH-1:0]  rd_data0,
   input  logic [ADDR_W-1:0] rd_addr1,
   output logic [WIDTH-1:0]  rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== rtl/xcorr_direction_compare.sv =====
// Top level of the cross-correlation direction compare block.
// Depends on xdc_pkg and xdc_ram.
//
// Usage: pairs of signed Q2.14 samples arrive on the req_ stream, one pair per
// transfer, with req_tlast on the final pair of a block. Up to BLOCK_SIZE
// pairs are held in two sample RAMs; further pairs are dropped and flagged.
// Pairs are taken back to back while loading. After the last pair the
// block is not ready while it sweeps all lags with two multiply-accumulate
// units (one per side) fed by the dual read ports of the sample RAMs: one
// term per cycle, n*(n+1)/2 terms for n pairs held, then pipeline drain,
// saturation and compare. This sweep sets the throughput: the next block's
// pairs wait for it. One result per block leaves on the rsp_ stream with the
// direction code, both saturated Q13.28 peaks and the drop flag (rsp_tuser).
// The result is held in an output register until taken; loading of the next
// block goes on meanwhile, and a further finished block waits for it.
// csr_ writes the equal_epsilon register (always ready, write while idle).
// Reset (synchronous, active high) empties the block, clears the drop flag,
// drops any pending result and returns equal_epsilon to 0.1. The sample
// RAMs are not cleared; only entries of the current block are read.
module xcorr_direction_compare #(
   parameter int BLOCK_SIZE = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: sample_a [15:0], sample_b [31:16]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [xdc_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        req_tlast,
   // rsp_tdata: direction [1:0], left_max [42:2], right_max [83:43], zeros
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [xdc_pkg::RSP_W-1:0]   rsp_tdata,
   // rsp_tuser: overflow [0]
   output logic                        rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [xdc_pkg::EPS_W-1:0]   csr_data
);

   localparam int AW     = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int CW     = $clog2(BLOCK_SIZE + 1);
   localparam int PROD_W = 2 * xdc_pkg::SAMPLE_W;
   localparam int ACC_W  = PROD_W + AW;
   localparam int EXT_W  = (ACC_W > xdc_pkg::DIFF_W) ? ACC_W : xdc_pkg::DIFF_W;
   localparam int PAD_W  = xdc_pkg::RSP_W - 2 - 2 * xdc_pkg::PEAK_W;

   localparam logic signed [EXT_W-1:0] LIM_POS = EXT_W'(xdc_pkg::PEAK_LIMIT);
   localparam logic signed [EXT_W-1:0] LIM_NEG = -LIM_POS;

   xdc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  fill_ff, fill_in;
   logic           drop_ff, drop_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           blk_drop_ff, blk_drop_in;
   logic [AW-1:0]  lag_ff, lag_in;
   logic [AW-1:0]  k_ff, k_in;
   logic [xdc_pkg::EPS_W-1:0] eps_ff, eps_in;

   // Sample RAM signals
   logic                         wr_en;
   logic [AW-1:0]                hi_addr;
   logic [AW:0]                  hi_sum;
   logic [xdc_pkg::SAMPLE_W-1:0] a_hi, a_lo, b_hi, b_lo;

   // MAC pipeline
   xdc_pkg::tag_type tag0, tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod_l_ff, prod_r_ff;
   logic signed [ACC_W-1:0]  acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic signed [ACC_W-1:0]  best_l_ff, best_l_in, best_r_ff, best_r_in;

   // Peak finishing
   logic signed [EXT_W-1:0]            ext_l, ext_r;
   logic signed [xdc_pkg::PEAK_W-1:0]  lp_ff, lp_in, rp_ff, rp_in;
   logic signed [xdc_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic [xdc_pkg::DIFF_W-1:0]         mag;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [xdc_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                       rsp_user_ff, rsp_user_in;
   logic [1:0]                 dir;

   logic req_xfer, has_room, last_term, last_lag, out_free;

   assign req_tready = (state_ff == xdc_pkg::ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign has_room   = (fill_ff < CW'(BLOCK_SIZE));
   assign wr_en      = req_xfer && has_room;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Term address: k + lag, and lag / term end detection
   assign hi_sum    = {1'b0, k_ff} + {1'b0, lag_ff};
   assign hi_addr   = hi_sum[AW-1:0];
   assign last_term = (hi_sum == (AW+1)'(n_ff - CW'(1)));
   assign last_lag  = ({1'b0, lag_ff} == (AW+1)'(n_ff - CW'(1)));

   assign tag0.valid = (state_ff == xdc_pkg::ST_CALC);
   assign tag0.first = (k_ff == '0);
   assign tag0.lastk = last_term;
   assign tag0.lag0  = (lag_ff == '0);

   // Port 0 feeds the left side (A shifted), port 1 the right side
   xdc_ram #(.WIDTH(xdc_pkg::SAMPLE_W), .DEPTH(BLOCK_SIZE)) u_ram_a (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (fill_ff[AW-1:0]),
      .wr_data  (req_tdata[xdc_pkg::SAMPLE_W-1:0]),
      .rd_addr0 (hi_addr),
      .rd_data0 (a_hi),
      .rd_addr1 (k_ff),
      .rd_data1 (a_lo)
   );

   xdc_ram #(.WIDTH(xdc_pkg::SAMPLE_W), .DEPTH(BLOCK_SIZE)) u_ram_b (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (fill_ff[AW-1:0]),
      .wr_data  (req_tdata[xdc_pkg::REQ_W-1:xdc_pkg::SAMPLE_W]),
      .rd_addr0 (k_ff),
      .rd_data0 (b_lo),
      .rd_addr1 (hi_addr),
      .rd_data1 (b_hi)
   );

   // Sequencer, fill tracking and lag/term counters
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      n_in        = n_ff;
      blk_drop_in = blk_drop_ff;
      lag_in      = lag_ff;
      k_in        = k_ff;
      case (state_ff)
         xdc_pkg::ST_LOAD: begin
            if (req_xfer) begin
               if (has_room) begin
                  fill_in = fill_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in        = has_room ? fill_ff + CW'(1) : fill_ff;
                  blk_drop_in = !has_room || drop_ff;
                  fill_in     = '0;
                  drop_in     = 1'b0;
                  lag_in      = '0;
                  k_in        = '0;
                  state_in    = xdc_pkg::ST_CALC;
               end
            end
         end
         xdc_pkg::ST_CALC: begin
            if (last_term) begin
               k_in = '0;
               if (last_lag) begin
                  state_in = xdc_pkg::ST_DRAIN;
               end else begin
                  lag_in = lag_ff + AW'(1);
               end
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         xdc_pkg::ST_DRAIN: begin
            if (!tag1_ff.valid && !tag2_ff.valid && !tag3_ff.valid) begin
               state_in = xdc_pkg::ST_CLAMP;
            end
         end
         xdc_pkg::ST_CLAMP: begin
            state_in = xdc_pkg::ST_DIFF;
         end
         xdc_pkg::ST_DIFF: begin
            state_in = xdc_pkg::ST_FINISH;
         end
         xdc_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = xdc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = xdc_pkg::ST_LOAD;
         end
      endcase
   end

   // Accumulate each lag, then keep the larger sum per side
   always_comb begin
      acc_l_in  = tag2_ff.first ? ACC_W'(prod_l_ff) : acc_l_ff + ACC_W'(prod_l_ff);
      acc_r_in  = tag2_ff.first ? ACC_W'(prod_r_ff) : acc_r_ff + ACC_W'(prod_r_ff);
      best_l_in = best_l_ff;
      best_r_in = best_r_ff;
      if (tag3_ff.valid && tag3_ff.lastk) begin
         if (tag3_ff.lag0 || (acc_l_ff > best_l_ff)) begin
            best_l_in = acc_l_ff;
         end
         if (tag3_ff.lag0 || (acc_r_ff > best_r_ff)) begin
            best_r_in = acc_r_ff;
         end
      end
   end

   // Saturate peaks, then take their difference
   always_comb begin
      ext_l = EXT_W'(best_l_ff);
      ext_r = EXT_W'(best_r_ff);
      if (ext_l > LIM_POS) begin
         ext_l = LIM_POS;
      end else if (ext_l < LIM_NEG) begin
         ext_l = LIM_NEG;
      end
      if (ext_r > LIM_POS) begin
         ext_r = LIM_POS;
      end else if (ext_r < LIM_NEG) begin
         ext_r = LIM_NEG;
      end
      lp_in   = (state_ff == xdc_pkg::ST_CLAMP) ? ext_l[xdc_pkg::PEAK_W-1:0] : lp_ff;
      rp_in   = (state_ff == xdc_pkg::ST_CLAMP) ? ext_r[xdc_pkg::PEAK_W-1:0] : rp_ff;
      diff_in = (state_ff == xdc_pkg::ST_DIFF)
              ? xdc_pkg::DIFF_W'(lp_ff) - xdc_pkg::DIFF_W'(rp_ff) : diff_ff;
   end

   // Classify and load the output register
   always_comb begin
      mag = diff_ff[xdc_pkg::DIFF_W-1] ? -diff_ff : diff_ff;
      if (mag < {2'b00, eps_ff}) begin
         dir = xdc_pkg::DIR_BOTH;
      end else if (!diff_ff[xdc_pkg::DIFF_W-1] && (diff_ff != '0)) begin
         dir = xdc_pkg::DIR_RIGHT;
      end else begin
         dir = xdc_pkg::DIR_LEFT;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if ((state_ff == xdc_pkg::ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, rp_ff, lp_ff, dir};
         rsp_user_in  = blk_drop_ff;
      end
      eps_in = csr_valid ? csr_data : eps_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xdc_pkg::ST_LOAD;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= xdc_pkg::EPS_RESET;
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         eps_ff       <= eps_in;
         tag1_ff      <= tag0;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      blk_drop_ff <= blk_drop_in;
      lag_ff      <= lag_in;
      k_ff        <= k_in;
      prod_l_ff   <= $signed(a_hi) * $signed(b_lo);
      prod_r_ff   <= $signed(a_lo) * $signed(b_hi);
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
      best_l_ff   <= best_l_in;
      best_r_ff   <= best_r_in;
      lp_ff       <= lp_in;
      rp_ff       <= rp_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
